FILE: hdl/alert_tone_pattern_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Alert tone pattern sequencer assertion macros
// Concurrent assertion shorthands, clocked on rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef ALERT_TONE_PATTERN_SEQUENCER_MACROS_SVH
`define ALERT_TONE_PATTERN_SEQUENCER_MACROS_SVH

// same-cycle implication
`define ATPS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication
`define ATPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

FILE: hdl/atps_pkg.sv
// ----------------------------------------------------------------------------
// atps_pkg
// Item types, event codes and the note table of the alert tone sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package atps_pkg;

  localparam logic [1:0] MODE_TICK       = 2'd0;
  localparam logic [1:0] MODE_TRANSITION = 2'd1;
  localparam logic [1:0] MODE_MUTE       = 2'd2;

  localparam logic [1:0] KIND_SILENT     = 2'd0;
  localparam logic [1:0] KIND_HUMAN      = 2'd1;
  localparam logic [1:0] KIND_COMPLETED  = 2'd2;
  localparam logic [1:0] KIND_ERROR      = 2'd3;

  localparam logic [2:0] NOTE_LAST       = 3'd6;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now;
    logic [1:0]  alert_kind;
    logic        mute_value;
  } in_item_t;

  typedef struct packed {
    logic        tone_start;
    logic [15:0] tone_freq_hz;
    logic [15:0] tone_length_ms;
    logic        tone_stop;
    logic        is_playing;
    logic        is_muted;
  } out_item_t;

  typedef struct packed {
    logic        playing;
    logic [1:0]  pattern_choice;
    logic [1:0]  note_position;
    logic [31:0] next_due_time;
    logic        mute_flag;
  } seq_state_t;

  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] dur;
    logic [15:0] span;
  } note_t;

  function automatic note_t note_lookup(input logic [2:0] idx);
    note_t n;
    unique case (idx)
      3'd0:    n = '{freq: 16'd784,  dur: 16'd110, span: 16'd180};
      3'd1:    n = '{freq: 16'd988,  dur: 16'd110, span: 16'd180};
      3'd2:    n = '{freq: 16'd1175, dur: 16'd150, span: 16'd150};
      3'd3:    n = '{freq: 16'd660,  dur: 16'd100, span: 16'd155};
      3'd4:    n = '{freq: 16'd880,  dur: 16'd150, span: 16'd150};
      3'd5:    n = '{freq: 16'd440,  dur: 16'd150, span: 16'd220};
      default: n = '{freq: 16'd330,  dur: 16'd220, span: 16'd220};
    endcase
    return n;
  endfunction

  function automatic logic [2:0] pattern_base(input logic [1:0] choice);
    logic [2:0] b;
    unique case (choice)
      KIND_COMPLETED: b = 3'd3;
      KIND_ERROR:     b = 3'd5;
      default:        b = 3'd0;
    endcase
    return b;
  endfunction

  function automatic logic [1:0] pattern_length(input logic [1:0] choice);
    logic [1:0] l;
    unique case (choice)
      KIND_HUMAN:     l = 2'd3;
      KIND_COMPLETED: l = 2'd2;
      KIND_ERROR:     l = 2'd2;
      default:        l = 2'd0;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/atps_step.sv
// ----------------------------------------------------------------------------
// atps_step
// Next state and result item for one event, from the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module atps_step (
  input  atps_pkg::in_item_t   item,
  input  atps_pkg::seq_state_t state,
  output atps_pkg::seq_state_t state_next,
  output atps_pkg::out_item_t  result
);

  logic [31:0]   elapsed;
  logic [3:0]    idx_sum;
  logic [2:0]    note_idx;
  atps_pkg::note_t note;

  assign elapsed  = item.now - state.next_due_time;
  assign idx_sum  = {1'b0, atps_pkg::pattern_base(state.pattern_choice)}
                  + {2'b00, state.note_position};
  assign note_idx = (idx_sum > {1'b0, atps_pkg::NOTE_LAST}) ? atps_pkg::NOTE_LAST
                                                            : idx_sum[2:0];
  assign note     = atps_pkg::note_lookup(note_idx);

  always_comb begin
    state_next = state;
    result     = '0;
    unique case (item.mode)
      atps_pkg::MODE_TRANSITION: begin
        state_next.playing        = 1'b0;
        state_next.pattern_choice = atps_pkg::KIND_SILENT;
        state_next.note_position  = 2'd0;
        result.tone_stop          = 1'b1;
        if (!state.mute_flag && item.alert_kind != atps_pkg::KIND_SILENT) begin
          state_next.playing        = 1'b1;
          state_next.pattern_choice = item.alert_kind;
          state_next.next_due_time  = item.now;
        end
      end
      atps_pkg::MODE_TICK: begin
        if (state.playing && !elapsed[31]) begin
          if (state.note_position >= atps_pkg::pattern_length(state.pattern_choice)) begin
            state_next.playing        = 1'b0;
            state_next.pattern_choice = atps_pkg::KIND_SILENT;
            state_next.note_position  = 2'd0;
            result.tone_stop          = 1'b1;
          end else begin
            state_next.note_position = state.note_position + 2'd1;
            state_next.next_due_time = item.now + {16'd0, note.span};
            result.tone_start        = 1'b1;
            result.tone_freq_hz      = note.freq;
            result.tone_length_ms    = note.dur;
          end
        end
      end
      atps_pkg::MODE_MUTE: begin
        if (state.mute_flag != item.mute_value) begin
          state_next.mute_flag = item.mute_value;
          if (item.mute_value) begin
            state_next.playing        = 1'b0;
            state_next.pattern_choice = atps_pkg::KIND_SILENT;
            state_next.note_position  = 2'd0;
            result.tone_stop          = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    result.is_playing = state_next.playing;
    result.is_muted   = state_next.mute_flag;
  end

endmodule

`default_nettype wire

FILE: hdl/alert_tone_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// alert_tone_pattern_sequencer
// Plays fixed alert tone patterns on tick, transition and mute events.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on in_valid/in_ready/in_data: a time tick, a state transition
//   naming an alert kind, or a mute setting. Every accepted event yields
//   exactly one result item on out_valid/out_ready/out_data, telling whether a
//   note starts (with its frequency and length), whether the speaker must stop,
//   and the playing and mute flags after the event.
//   The result is registered on the edge that accepts the event. Throughput
//   is one event per cycle while the receiver keeps up; the table lookup,
//   the deadline subtract and the re-arm add all settle before that edge.
//   in_ready is high whenever the result register is empty or being drained
//   in the same cycle, so a stalled receiver holds the result and stalls the
//   input after one item.
//   Reset clears the pattern state, the deadline and the mute flag, and
//   empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module alert_tone_pattern_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  atps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output atps_pkg::out_item_t out_data
);

  atps_pkg::seq_state_t state;
  atps_pkg::seq_state_t state_next;
  atps_pkg::out_item_t  result;
  logic                 accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  atps_step u_step (
    .item       (in_data),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/atps_checker.sv
// ----------------------------------------------------------------------------
// atps_checker
// Port-level checks on the alert tone sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "alert_tone_pattern_sequencer_macros.svh"

module atps_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input atps_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input atps_pkg::out_item_t out_data
);

  `ATPS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

  `ATPS_ASSERT_SAME(a_start_stop_excl, clk, rst, out_valid, !(out_data.tone_start && out_data.tone_stop))

  `ATPS_ASSERT_SAME(a_start_playing, clk, rst, out_valid && out_data.tone_start, out_data.is_playing)

  `ATPS_ASSERT_SAME(a_idle_tone_zero, clk, rst, out_valid && !out_data.tone_start, out_data.tone_freq_hz == 16'd0 && out_data.tone_length_ms == 16'd0)

  `ATPS_ASSERT_NEXT(a_mute_follows, clk, rst, in_valid && in_ready && in_data.mode == atps_pkg::MODE_MUTE, out_valid && out_data.is_muted == $past(in_data.mute_value))

endmodule

bind alert_tone_pattern_sequencer atps_checker u_checker (.*);

`default_nettype wire

FILE: sim/tone_sequence_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_sequence_checker
// Watches the event and result channels of the alert tone sequencer. Keeps
// its own copy of the pattern state, predicts one result item per accepted
// event and compares every returned item in order, field by field.
// ----------------------------------------------------------------------------

module tone_sequence_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  atps_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  atps_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_results
);
  import atps_pkg::*;

  logic        playing;
  logic [1:0]  chosen;
  logic [1:0]  position;
  logic [31:0] due_ms;
  logic        muted;
  out_item_t   expected_tones[$];
  int          mismatches = 0;

  function automatic void stop_pattern();
    playing  = 1'b0;
    chosen   = KIND_SILENT;
    position = 2'd0;
  endfunction

  function automatic out_item_t play_event(in_item_t ev);
    out_item_t   r;
    logic [31:0] lag;
    logic [2:0]  first;
    logic [1:0]  count;
    logic [3:0]  idx;
    logic [15:0] freq;
    logic [15:0] dur;
    logic [15:0] gap;
    r   = '0;
    lag = ev.now - due_ms;
    case (chosen)
      KIND_HUMAN:     begin first = 3'd0; count = 2'd3; end
      KIND_COMPLETED: begin first = 3'd3; count = 2'd2; end
      KIND_ERROR:     begin first = 3'd5; count = 2'd2; end
      default:        begin first = 3'd0; count = 2'd0; end
    endcase
    idx = {1'b0, first} + {2'b00, position};
    if (idx > 4'd6) idx = 4'd6;
    case (idx)
      4'd0:    {freq, dur, gap} = {16'd784,  16'd110, 16'd70};
      4'd1:    {freq, dur, gap} = {16'd988,  16'd110, 16'd70};
      4'd2:    {freq, dur, gap} = {16'd1175, 16'd150, 16'd0};
      4'd3:    {freq, dur, gap} = {16'd660,  16'd100, 16'd55};
      4'd4:    {freq, dur, gap} = {16'd880,  16'd150, 16'd0};
      4'd5:    {freq, dur, gap} = {16'd440,  16'd150, 16'd70};
      default: {freq, dur, gap} = {16'd330,  16'd220, 16'd0};
    endcase
    case (ev.mode)
      MODE_TRANSITION: begin
        stop_pattern();
        r.tone_stop = 1'b1;
        if (!muted && ev.alert_kind != KIND_SILENT) begin
          playing  = 1'b1;
          chosen   = ev.alert_kind;
          position = 2'd0;
          due_ms   = ev.now;
        end
      end
      MODE_TICK: begin
        if (playing && !lag[31]) begin
          if (position >= count) begin
            stop_pattern();
            r.tone_stop = 1'b1;
          end else begin
            position         = position + 2'd1;
            r.tone_start     = 1'b1;
            r.tone_freq_hz   = freq;
            r.tone_length_ms = dur;
            due_ms           = ev.now + {16'd0, dur} + {16'd0, gap};
          end
        end
      end
      MODE_MUTE: begin
        if (muted != ev.mute_value) begin
          muted = ev.mute_value;
          if (muted) begin
            stop_pattern();
            r.tone_stop = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.is_playing = playing;
    r.is_muted   = muted;
    return r;
  endfunction

  task automatic log_mismatch(string why, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch, %s: expected start=%0b freq=%0d len=%0d stop=%0b play=%0b mute=%0b",
               why, want.tone_start, want.tone_freq_hz, want.tone_length_ms,
               want.tone_stop, want.is_playing, want.is_muted);
    if (mismatches <= 10)
      $display("  actual start=%0b freq=%0d len=%0d stop=%0b play=%0b mute=%0b",
               got.tone_start, got.tone_freq_hz, got.tone_length_ms,
               got.tone_stop, got.is_playing, got.is_muted);
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      playing  = 1'b0;
      chosen   = KIND_SILENT;
      position = 2'd0;
      due_ms   = 32'd0;
      muted    = 1'b0;
      expected_tones.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tones.size() == 0) begin
          log_mismatch("item with nothing expected", '0, out_data);
        end else begin
          want = expected_tones.pop_front();
          if (want.tone_start !== out_data.tone_start ||
              want.tone_freq_hz !== out_data.tone_freq_hz ||
              want.tone_length_ms !== out_data.tone_length_ms ||
              want.tone_stop !== out_data.tone_stop ||
              want.is_playing !== out_data.is_playing ||
              want.is_muted !== out_data.is_muted)
            log_mismatch("wrong field", want, out_data);
        end
      end
      if (in_valid && in_ready)
        expected_tones.push_back(play_event(in_data));
    end
    fail_count      <= mismatches;
    pending_results <= expected_tones.size();
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives tick, transition and mute events into the alert tone sequencer:
// a directed opening through wraparound deadlines, every pattern and the
// mute paths, then random pattern sequences mixed with noise, under bursty
// sending and a stalling receiver. The checker beside the block does the
// prediction; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_top;
  import atps_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STIM_EVENTS = 1800;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  int          fail_count;
  int          pending_results;
  int          cycle_count = 0;
  int          burst_left = 0;
  bit          steady_send = 1'b0;
  int          stall_style = 0;
  int          stall_left = 0;
  logic [31:0] clock_ms;

  alert_tone_pattern_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  tone_sequence_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 2);
      stall_left  <= $urandom_range(64, 512);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic in_item_t make_event(logic [1:0] mode, logic [31:0] now,
                                          logic [1:0] kind, logic mute);
    in_item_t ev;
    ev.mode       = mode;
    ev.now        = now;
    ev.alert_kind = kind;
    ev.mute_value = mute;
    return ev;
  endfunction

  function automatic in_item_t random_event();
    in_item_t    ev;
    logic [31:0] bits;
    bits          = $urandom;
    ev.mode       = bits[1:0];
    ev.alert_kind = bits[3:2];
    ev.mute_value = bits[4];
    ev.now        = $urandom;
    return ev;
  endfunction

  function automatic logic [31:0] step_ms();
    case ($urandom_range(0, 19))
      0, 1:    return 32'd0;
      2, 3:    return 32'd150;
      4:       return 32'd155;
      5, 6:    return 32'd180;
      7, 8:    return 32'd220;
      9, 10:   return 32'($urandom_range(1, 60));
      11:      return $urandom;
      default: return 32'($urandom_range(100, 260));
    endcase
  endfunction

  task automatic send_event(in_item_t ev);
    int idle;
    idle = 0;
    if (!steady_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        idle       = $urandom_range(1, 6);
      end
      burst_left--;
    end
    repeat (idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data  <= random_event();
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin : stimulus
    int         sent;
    int         notes;
    logic [1:0] kind;
    in_item_t   ev;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    send_event(make_event(MODE_TICK, 32'd0, KIND_SILENT, 1'b0));
    send_event(make_event(MODE_UNUSED, 32'hFFFF_FFFF, KIND_ERROR, 1'b1));
    send_event(make_event(MODE_TRANSITION, 32'd0, KIND_SILENT, 1'b0));
    send_event(make_event(MODE_TRANSITION, 32'hFFFF_FF80, KIND_HUMAN, 1'b1));
    send_event(make_event(MODE_TICK, 32'hFFFF_FF7F, KIND_ERROR, 1'b0));
    send_event(make_event(MODE_TICK, 32'hFFFF_FF80, KIND_SILENT, 1'b0));
    send_event(make_event(MODE_TICK, 32'hFFFF_FFFF, KIND_SILENT, 1'b1));
    send_event(make_event(MODE_TICK, 32'h0000_0034, KIND_SILENT, 1'b0));
    send_event(make_event(MODE_TICK, 32'h0000_00E8, KIND_SILENT, 1'b0));
    send_event(make_event(MODE_TICK, 32'h0000_0200, KIND_SILENT, 1'b0));
    send_event(make_event(MODE_TICK, 32'h0000_0300, KIND_SILENT, 1'b0));
    send_event(make_event(MODE_TRANSITION, 32'h0000_1000, KIND_COMPLETED, 1'b0));
    send_event(make_event(MODE_TICK, 32'h0000_1000, KIND_SILENT, 1'b0));
    send_event(make_event(MODE_TRANSITION, 32'h0000_1050, KIND_ERROR, 1'b0));
    send_event(make_event(MODE_TICK, 32'h0000_1050, KIND_SILENT, 1'b0));
    send_event(make_event(MODE_MUTE, 32'h0000_1060, KIND_SILENT, 1'b1));
    send_event(make_event(MODE_MUTE, 32'h0000_1070, KIND_HUMAN, 1'b1));
    send_event(make_event(MODE_TRANSITION, 32'h0000_1080, KIND_HUMAN, 1'b0));
    send_event(make_event(MODE_MUTE, 32'h0000_1090, KIND_SILENT, 1'b0));
    send_event(make_event(MODE_MUTE, 32'h0000_10A0, KIND_SILENT, 1'b0));
    send_event(make_event(MODE_TRANSITION, 32'h8000_0000, KIND_ERROR, 1'b0));
    send_event(make_event(MODE_TICK, 32'h8000_0000, KIND_SILENT, 1'b0));
    send_event(make_event(MODE_TICK, 32'h8000_00DC, KIND_SILENT, 1'b0));
    send_event(make_event(MODE_TICK, 32'h0000_00DB, KIND_SILENT, 1'b0));
    send_event(make_event(MODE_UNUSED, 32'd0, KIND_SILENT, 1'b0));

    clock_ms = $urandom;
    sent = 0;
    while (sent < STIM_EVENTS) begin
      if ($urandom_range(0, 59) == 0) steady_send = !steady_send;
      if ($urandom_range(0, 24) == 0) clock_ms = $urandom;
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 3) == 0) begin
          send_event(make_event(MODE_MUTE, clock_ms, 2'($urandom_range(0, 3)), 1'b0));
          sent++;
        end
        kind = ($urandom_range(0, 9) == 0) ? KIND_SILENT : 2'($urandom_range(1, 3));
        send_event(make_event(MODE_TRANSITION, clock_ms, kind, 1'($urandom_range(0, 1))));
        sent++;
        notes = $urandom_range(2, 6);
        repeat (notes) begin
          clock_ms = clock_ms + step_ms();
          ev = random_event();
          ev.now = clock_ms;
          case ($urandom_range(0, 19))
            0:       begin ev.mode = MODE_MUTE; ev.mute_value = 1'b1; end
            1:       ev.mode = MODE_TRANSITION;
            default: ev.mode = MODE_TICK;
          endcase
          send_event(ev);
          sent++;
        end
      end else begin
        ev = random_event();
        send_event(ev);
        if (ev.mode != MODE_UNUSED) sent++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: alert_tone_pattern_sequencer.f
+incdir+hdl
hdl/atps_pkg.sv
hdl/atps_step.sv
hdl/alert_tone_pattern_sequencer.sv
hdl/atps_checker.sv
sim/tone_sequence_checker.sv
sim/tb_top.sv
